FILE: rtl/arlc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Reply line classifier package
// Shared constants, codes and keyword-matching helpers for the modem reply
// line classifier.
// ----------------------------------------------------------------------------
package arlc_pkg;

	// Defaults for the top-level parameters.
	localparam int BUFFER_BYTES_DEF = 128;
	localparam int MAX_LINES_DEF    = 8;

	// Register reset values.
	localparam logic [3:0] LINE_LIMIT_RESET    = 4'd8;
	localparam logic [7:0] TIMEOUT_TICKS_RESET = 8'd200;

	// Register decode: the registers are word aligned, so bit 2 of the
	// address picks one of the two.
	localparam int   REG_SEL_BIT        = 2;
	localparam logic REG_IDX_LINE_LIMIT = 1'b0;
	localparam logic REG_IDX_TIMEOUT    = 1'b1;

	// Special characters.
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_PROMPT = 8'h3E;

	// Input item kinds.
	typedef enum logic [1:0] {
		MODE_BYTE    = 2'd0,
		MODE_TICK    = 2'd1,
		MODE_RESTART = 2'd2
	} mode_t;

	// Result verdicts; ok, error and fail share their codes with the keyword
	// match codes below.
	typedef enum logic [2:0] {
		V_PENDING = 3'd0,
		V_OK      = 3'd1,
		V_ERROR   = 3'd2,
		V_FAIL    = 3'd3,
		V_PROMPT  = 3'd4,
		V_TIMEOUT = 3'd5
	} verdict_t;

	// Line framing phases.
	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_TEXT = 2'd1,
		PH_END  = 2'd2
	} phase_t;

	// Keyword match code meaning no keyword.
	localparam logic [1:0] NO_WORD = 2'd0;

	// Keyword table: OK, ERROR and FAIL, padded with zeros to eight places.
	localparam int KW_NUM = 3;
	localparam logic [7:0] KW_TEXT [KW_NUM][8] = '{
		'{8'h4F, 8'h4B, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h45, 8'h52, 8'h52, 8'h4F, 8'h52, 8'h00, 8'h00, 8'h00},
		'{8'h46, 8'h41, 8'h49, 8'h4C, 8'h00, 8'h00, 8'h00, 8'h00}
	};
	localparam logic [2:0] KW_LEN [KW_NUM] = '{3'd2, 3'd5, 3'd4};

	// Drop every keyword that the byte at position pos does not continue.
	function automatic logic [KW_NUM-1:0] kw_feed(
		input logic [KW_NUM-1:0] alive,
		input logic [2:0]        pos,
		input logic [7:0]        b
	);
		logic [KW_NUM-1:0] res;
		res = alive;
		for (int k = 0; k < KW_NUM; k++) begin
			if (!((pos < KW_LEN[k]) && (KW_TEXT[k][pos] == b))) begin
				res[k] = 1'b0;
			end
		end
		return res;
	endfunction

	// Code of the first keyword that the text so far matches completely, or 0.
	function automatic logic [1:0] kw_full(
		input logic [KW_NUM-1:0] alive,
		input logic [2:0]        len
	);
		logic [1:0] code;
		code = NO_WORD;
		for (int k = KW_NUM - 1; k >= 0; k--) begin
			if (alive[k] && (len == KW_LEN[k])) begin
				code = 2'(k + 1);
			end
		end
		return code;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/arlc_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Reply classifier input channel
// Valid/ready channel carrying one received byte, poll tick or restart.
// ----------------------------------------------------------------------------
interface arlc_in_if;

	logic       valid;
	logic       ready;
	logic [1:0] mode;
	logic [7:0] data_byte;

	modport source (output valid, output mode, output data_byte, input ready);
	modport sink   (input valid, input mode, input data_byte, output ready);

endinterface
`default_nettype wire

FILE: rtl/arlc_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Reply classifier result channel
// Valid/ready channel carrying the status reported for each input transfer.
// ----------------------------------------------------------------------------
interface arlc_out_if;

	logic       valid;
	logic       ready;
	logic [2:0] verdict;
	logic       line_start_flag;
	logic [3:0] line_count;
	logic [7:0] byte_count;

	modport source (
		output valid, output verdict, output line_start_flag,
		output line_count, output byte_count, input ready
	);
	modport sink (
		input valid, input verdict, input line_start_flag,
		input line_count, input byte_count, output ready
	);

endinterface
`default_nettype wire

FILE: rtl/at_response_line_classifier.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Modem reply line classifier
// Splits a modem reply into CR/LF lines, matches completed lines against
// OK, ERROR and FAIL, and reports prompt and timeout verdicts.
// ----------------------------------------------------------------------------
// The block takes one transfer per clock cycle, back to back, while the result
// register is not stalled, and returns one result per transfer in the next
// cycle. All parsing state is updated from the registered state and the
// incoming transfer; the result register is the only stage, so a new transfer
// is taken whenever the result register is empty or drains in the same cycle.
// The two configuration registers (line limit and timeout ticks) should be
// written only while no transfer is in flight.
module at_response_line_classifier
	import arlc_pkg::*;
#(
	parameter int BUFFER_BYTES = BUFFER_BYTES_DEF,
	parameter int MAX_LINES    = MAX_LINES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	arlc_in_if.sink          byte_ch,
	arlc_out_if.source       result_ch,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);

	// Configuration registers.
	logic [3:0] line_limit_q;
	logic [7:0] timeout_ticks_q;

	// Parsing state.
	phase_t            phase_q, phase_n;
	logic [3:0]        lines_q, lines_n;
	logic [7:0]        bytes_q, bytes_n;
	logic [7:0]        ticks_q, ticks_n;
	logic [KW_NUM-1:0] alive_q, alive_n;
	logic [2:0]        mlen_q, mlen_n;
	logic              counted_q, counted_n;
	logic [1:0]        pmatch_q, pmatch_n;
	verdict_t          verdict_q, verdict_n;
	logic              start_n;

	// Result stage.
	logic       out_valid_s1;
	logic [2:0] verdict_s1;
	logic       start_s1;
	logic [3:0] lines_s1;
	logic [7:0] bytes_s1;

	logic       in_accept;
	logic       cfg_write;
	logic [3:0] eff_limit;
	logic [7:0] b;

	// Handshake: take a transfer when the result register is free or draining.
	assign byte_ch.ready = !out_valid_s1 || result_ch.ready;
	assign in_accept     = byte_ch.valid && byte_ch.ready;
	assign b             = byte_ch.data_byte;

	// Configuration port.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;
	assign prdata    = (paddr[REG_SEL_BIT] == REG_IDX_TIMEOUT) ?
		{24'd0, timeout_ticks_q} : {28'd0, line_limit_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_limit_q    <= LINE_LIMIT_RESET;
			timeout_ticks_q <= TIMEOUT_TICKS_RESET;
		end else if (cfg_write) begin
			if (paddr[REG_SEL_BIT] == REG_IDX_TIMEOUT) begin
				timeout_ticks_q <= pwdata[7:0];
			end else begin
				line_limit_q <= pwdata[3:0];
			end
		end
	end

	// A limit above the line capacity acts as the capacity.
	assign eff_limit = (line_limit_q > 4'(MAX_LINES)) ? 4'(MAX_LINES) : line_limit_q;

	// Next-state logic for the framing machine, matcher and counters.
	always_comb begin
		phase_n   = phase_q;
		lines_n   = lines_q;
		bytes_n   = bytes_q;
		ticks_n   = ticks_q;
		alive_n   = alive_q;
		mlen_n    = mlen_q;
		counted_n = counted_q;
		pmatch_n  = pmatch_q;
		verdict_n = verdict_q;
		start_n   = 1'b0;

		case (mode_t'(byte_ch.mode))
			MODE_RESTART: begin
				phase_n   = PH_IDLE;
				lines_n   = 4'd0;
				bytes_n   = 8'd0;
				ticks_n   = 8'd0;
				alive_n   = '1;
				mlen_n    = 3'd0;
				counted_n = 1'b0;
				pmatch_n  = NO_WORD;
				verdict_n = V_PENDING;
			end
			MODE_TICK: begin
				if (verdict_q == V_PENDING) begin
					if (ticks_q >= timeout_ticks_q) begin
						verdict_n = V_TIMEOUT;
					end else begin
						ticks_n = ticks_q + 8'd1;
					end
				end
			end
			MODE_BYTE: begin
				if (bytes_q < 8'(BUFFER_BYTES)) begin
					bytes_n = bytes_q + 8'd1;
					case (phase_q)
						PH_IDLE: begin
							if (lines_q < eff_limit) begin
								if (b != CH_CR) begin
									lines_n   = lines_q + 4'd1;
									start_n   = 1'b1;
									counted_n = 1'b1;
									alive_n   = kw_feed('1, 3'd0, b);
									mlen_n    = 3'd1;
									phase_n   = PH_TEXT;
								end else begin
									counted_n = 1'b0;
									pmatch_n  = NO_WORD;
									alive_n   = '0;
									mlen_n    = 3'd0;
									phase_n   = PH_END;
								end
							end
						end
						PH_TEXT: begin
							if (b == CH_CR) begin
								pmatch_n = kw_full(alive_q, mlen_q);
								phase_n  = PH_END;
							end
							alive_n = kw_feed(alive_q, mlen_q, b);
							mlen_n  = (mlen_q < 3'd7) ? mlen_q + 3'd1 : mlen_q;
						end
						default: begin
							// Line ending: LF closes the line, other bytes go on.
							if (b == CH_LF) begin
								if (counted_q && (pmatch_q != NO_WORD) &&
									(verdict_q == V_PENDING)) begin
									verdict_n = verdict_t'({1'b0, pmatch_q});
								end
								phase_n   = PH_IDLE;
								counted_n = 1'b0;
								pmatch_n  = NO_WORD;
							end else begin
								if (b != CH_CR) begin
									phase_n = PH_TEXT;
								end
								alive_n = kw_feed(alive_q, mlen_q, b);
								mlen_n  = (mlen_q < 3'd7) ? mlen_q + 3'd1 : mlen_q;
							end
						end
					endcase
					if ((b == CH_PROMPT) && (verdict_n == V_PENDING)) begin
						verdict_n = V_PROMPT;
					end
				end
			end
			default: begin
				// Unused mode: nothing changes.
			end
		endcase
	end

	// Framing phase register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
		end else if (in_accept) begin
			phase_q <= phase_n;
		end
	end

	// Counters, matcher and verdict registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lines_q   <= 4'd0;
			bytes_q   <= 8'd0;
			ticks_q   <= 8'd0;
			alive_q   <= '1;
			mlen_q    <= 3'd0;
			counted_q <= 1'b0;
			pmatch_q  <= NO_WORD;
			verdict_q <= V_PENDING;
		end else if (in_accept) begin
			lines_q   <= lines_n;
			bytes_q   <= bytes_n;
			ticks_q   <= ticks_n;
			alive_q   <= alive_n;
			mlen_q    <= mlen_n;
			counted_q <= counted_n;
			pmatch_q  <= pmatch_n;
			verdict_q <= verdict_n;
		end
	end

	// Result register: valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s1 <= 1'b0;
		end else if (in_accept) begin
			out_valid_s1 <= 1'b1;
		end else if (result_ch.ready) begin
			out_valid_s1 <= 1'b0;
		end
	end

	// Result register: payload.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			verdict_s1 <= verdict_n;
			start_s1   <= start_n;
			lines_s1   <= lines_n;
			bytes_s1   <= bytes_n;
		end
	end

	assign result_ch.valid           = out_valid_s1;
	assign result_ch.verdict         = verdict_s1;
	assign result_ch.line_start_flag = start_s1;
	assign result_ch.line_count      = lines_s1;
	assign result_ch.byte_count      = bytes_s1;

	// A given verdict holds until a restart transfer.
	a_verdict_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && (verdict_q != V_PENDING) &&
			(byte_ch.mode != MODE_RESTART)) |=> $stable(verdict_q))
		else $error("verdict changed without restart");

	// Line and byte counters stay within their capacities.
	a_counts_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(lines_q <= 4'(MAX_LINES)) && (bytes_q <= 8'(BUFFER_BYTES)))
		else $error("line or byte count beyond capacity");

	// A stalled result is not lost.
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_s1 && !result_ch.ready) |=> out_valid_s1)
		else $error("stalled result dropped");

	// A reported line start always comes with a nonzero line count.
	a_start_counted: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_s1 && start_s1) |-> (lines_s1 != 4'd0))
		else $error("line start reported with zero line count");

endmodule
`default_nettype wire
